// ===== rtl/dsd_pkg.sv =====
`timescale 1ns / 1ps
package dsd_pkg;
  localparam int HistBytes = 64;
  localparam int HistW = $clog2(HistBytes);
  localparam int TapCount = 512;
  localparam int TapW = $clog2(TapCount);
  localparam int CoefBits = 24;
  localparam int LockFrames = 32;
  localparam int ReleaseFrames = 64;
  localparam int RunW = 10;
  localparam logic [RunW-1:0] RunCap = 10'd1000;
  localparam logic [7:0] MarkA = 8'h05;
  localparam logic [7:0] MarkB = 8'hFA;
  localparam logic [7:0] Silence = 8'h69;
  localparam int AccW = CoefBits + TapW + 2;
  // tap sum times two, Q1.(CoefBits-1) to Q1.31
  localparam int FirShift = 33 - CoefBits;
  localparam int FirW = AccW + FirShift;

  localparam logic [0:0] RegMode = 1'b0;
  localparam logic [0:0] RegNatWidth = 1'b1;

  localparam logic [1:0] ModePass = 2'd0;
  localparam logic [1:0] ModeDop = 2'd1;
  localparam logic [1:0] ModeNative = 2'd2;
  localparam logic [1:0] NatW8 = 2'd0;
  localparam logic [1:0] NatW16 = 2'd1;
  localparam logic [1:0] NatW32 = 2'd2;

  // job handed from front to back
  typedef struct packed {
    logic        is_tap;
    logic [TapW-1:0] tap_index;
    logic signed [CoefBits-1:0] tap_value;
    logic        clear_hist;  // refill history with silence before pushes
    logic [2:0]  push_count;  // 0,1,2 or 4 bytes
    logic [31:0] push_bytes;  // bytes, first pushed at [31:24]
    logic        run_fir;
    logic        locked;
    logic [31:0] sample;
  } job_t;
endpackage

// ===== rtl/dsd_front.sv =====
`timescale 1ns / 1ps
module dsd_front (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic command,
  input  logic [31:0] sample,
  input  logic [8:0] tap_index,
  input  logic signed [23:0] tap_value,
  output logic job_valid,
  input  logic job_full,
  output dsd_pkg::job_t job
);
  import dsd_pkg::*;

  logic [1:0] decode_mode, native_width;
  logic [RunW-1:0] valid_run, invalid_run;
  logic lock_flag, wide_container, container_fixed;
  logic [7:0] previous_marker;

  logic [RunW-1:0] valid_run_next, invalid_run_next;
  logic lock_next, wide_next, fixed_next;
  logic [7:0] prev_next, m24, m32, marker;
  logic [15:0] word;
  logic ok24, ok32, valid, take;

  assign in_stall = job_full;
  assign take = in_valid && !job_full;
  assign job_valid = take;

  always_comb begin
    m24 = sample[31:24];
    m32 = sample[23:16];
    ok24 = (m24 == MarkA) || (m24 == MarkB);
    ok32 = (m32 == MarkA) || (m32 == MarkB);
    valid_run_next = valid_run;
    invalid_run_next = invalid_run;
    lock_next = lock_flag;
    wide_next = wide_container;
    fixed_next = container_fixed;
    prev_next = previous_marker;
    valid = 1'b0;
    marker = m24;
    word = sample[23:8];
    job = '0;
    job.sample = sample;
    job.tap_index = tap_index;
    job.tap_value = tap_value[CoefBits-1:0];
    if (command) begin
      job.is_tap = 1'b1;
    end else if (decode_mode == ModeNative) begin
      lock_next = 1'b1;
      job.push_bytes = sample;
      if (native_width == NatW8) job.push_count = 3'd1;
      else if (native_width == NatW32) job.push_count = 3'd4;
      else job.push_count = 3'd2;
    end else if (decode_mode == ModeDop) begin
      if (!container_fixed) begin
        if (ok24) wide_next = 1'b0;
        else if (ok32) wide_next = 1'b1;
      end
      if (wide_next && (container_fixed || !ok24)) begin
        marker = m32;
        word = sample[15:0];
      end
      valid = ((marker == MarkA) || (marker == MarkB)) &&
              (previous_marker == 8'd0 || marker != previous_marker);
      if (valid) begin
        if (valid_run < RunCap) valid_run_next = valid_run + 1'b1;
        invalid_run_next = '0;
        prev_next = marker;
        if (valid_run_next >= RunW'(4)) fixed_next = 1'b1;
        if (valid_run_next >= RunW'(LockFrames)) lock_next = 1'b1;
      end else begin
        if (invalid_run < RunCap) invalid_run_next = invalid_run + 1'b1;
        valid_run_next = '0;
        if (invalid_run_next >= RunW'(ReleaseFrames)) begin
          prev_next = 8'd0;
          fixed_next = 1'b0;
          if (lock_flag) begin
            lock_next = 1'b0;
            job.clear_hist = 1'b1;
          end
        end
      end
      if (valid || lock_next) begin
        job.push_count = 3'd2;
        job.push_bytes = {word, 16'd0};
      end
    end
    if (!command && (decode_mode == ModeDop || decode_mode == ModeNative))
      job.run_fir = lock_next;
    job.locked = (decode_mode == ModeDop || decode_mode == ModeNative) ? lock_next
                                                                         : lock_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= ModePass;
      native_width <= NatW16;
      valid_run <= '0;
      invalid_run <= '0;
      lock_flag <= 1'b0;
      wide_container <= 1'b0;
      container_fixed <= 1'b0;
      previous_marker <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == RegMode) decode_mode <= cfg_data;
        else native_width <= cfg_data;
      end
      if (take && !command) begin
        valid_run <= valid_run_next;
        invalid_run <= invalid_run_next;
        lock_flag <= lock_next;
        wide_container <= wide_next;
        container_fixed <= fixed_next;
        previous_marker <= prev_next;
      end
    end
  end

  a_lock_on_native: assert property (@(posedge clk) disable iff (rst)
    (take && !command && decode_mode == ModeNative) |=> lock_flag)
    else $error("native frame left lock clear");
  a_clear_only_release: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.clear_hist) |-> (lock_flag && !job.locked))
    else $error("history clear without release");
  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    (valid_run == '0) || (invalid_run == '0))
    else $error("both run counters nonzero");
endmodule

// ===== rtl/dsd_back.sv =====
`timescale 1ns / 1ps
module dsd_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_take,
  input  dsd_pkg::job_t job,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pcm_out,
  output logic decoded,
  output logic locked
);
  import dsd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_PUSH  = 5'b00100,
    S_FIR   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;
  logic [7:0] hist [HistBytes];
  logic [HistW-1:0] hptr;
  logic [HistW:0] fill;   // bytes written since the last refill
  logic signed [CoefBits-1:0] taps [TapCount];
  job_t cur;
  logic [2:0] pushed;
  logic [HistW:0] bidx;   // byte offset behind newest
  logic [2:0] bit_i;
  logic signed [AccW-1:0] acc;
  logic signed [CoefBits-1:0] tap_q;
  logic tap_q_ok;
  logic [7:0] hist_q;
  logic hist_ok_q;
  logic [2:0] bit_q;
  logic fir_bit;
  logic [HistW-1:0] hist_addr;
  logic [TapW-1:0] rd_addr;
  logic rd_ok;
  logic push_now, out_free, emit;
  logic signed [FirW-1:0] y;

  assign job_take = (state == S_IDLE) && job_valid;
  assign push_now = (state == S_PUSH) && (pushed < cur.push_count);
  assign out_free = !out_valid || !out_stall;
  assign emit = out_free && ((state == S_OUT) ||
                ((state == S_PUSH) && !push_now && !cur.run_fir));

  always_comb begin
    hist_addr = hptr - 1'b1 - bidx[HistW-1:0];
    rd_addr = TapW'({bidx, bit_i});
    rd_ok = (state == S_FIR) && !bidx[HistW] && ({bidx, bit_i} < TapCount);
    // slots not written since the last refill read as silence
    fir_bit = hist_ok_q ? hist_q[bit_q] : Silence[bit_q];
    y = FirW'(acc) <<< FirShift;
  end

  // tap and history memories, one read each per cycle
  always_ff @(posedge clk) begin
    if (job_take && job.is_tap) taps[job.tap_index] <= job.tap_value;
    if (push_now) hist[hptr] <= cur.push_bytes[31:24];
    tap_q <= taps[rd_addr];
    hist_q <= hist[hist_addr];
    hist_ok_q <= (bidx < fill);
    bit_q <= bit_i;
    tap_q_ok <= rd_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hptr <= '0;
      fill <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (tap_q_ok) acc <= fir_bit ? acc + AccW'(tap_q) : acc - AccW'(tap_q);
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            pushed <= '0;
            if (job.is_tap) state <= S_IDLE;
            else if (job.clear_hist) state <= S_CLEAR;
            else state <= S_PUSH;
          end
        end
        S_CLEAR: begin
          hptr <= '0;
          fill <= '0;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_now) begin
            cur.push_bytes <= {cur.push_bytes[23:0], 8'd0};
            hptr <= hptr + 1'b1;
            if (fill != (HistW+1)'(HistBytes)) fill <= fill + 1'b1;
            pushed <= pushed + 1'b1;
          end else if (cur.run_fir) begin
            acc <= '0;
            bidx <= '0;
            bit_i <= '0;
            state <= S_FIR;
          end else if (out_free) begin
            pcm_out <= cur.sample;
            decoded <= 1'b0;
            locked <= cur.locked;
            state <= S_IDLE;
          end
        end
        S_FIR: begin
          {bidx, bit_i} <= {bidx, bit_i} + 1'b1;
          if (!rd_ok && !tap_q_ok) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (y > FirW'(32'sh7FFFFFFF)) pcm_out <= 32'sh7FFFFFFF;
            else if (y < FirW'(32'sh80000000)) pcm_out <= 32'sh80000000;
            else pcm_out <= y[31:0];
            decoded <= 1'b1;
            locked <= cur.locked;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    job_take |-> state == S_IDLE)
    else $error("job taken while busy");
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_PUSH || $past(state) == S_OUT))
    else $error("word emitted from wrong state");
endmodule

// ===== rtl/dop_dsd_lock_and_decimator_top.sv =====
`timescale 1ns / 1ps
// A frame's bytes are pushed into the history; a locked frame then reads all
// 512 taps serially through a registered read stage and gives its word, other
// frames give their sample after the pushes, a release first refills the
// history, and a tap write is stored when the back end takes it. One word is in
// the back end while the next waits in the queue; output stalls hold both.
// Reset: synchronous, active high; history reads 0x69 until written, taps undefined.
module dop_dsd_lock_and_decimator_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic command,
  input  logic [31:0] sample,
  input  logic [8:0] tap_index,
  input  logic signed [23:0] tap_value,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pcm_out,
  output logic decoded,
  output logic locked
);
  import dsd_pkg::*;

  job_t fjob, qjob;
  logic fvalid, qfull, take;

  dsd_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .command, .sample, .tap_index, .tap_value,
    .job_valid(fvalid), .job_full(qfull), .job(fjob)
  );

  // one-entry queue between front and back
  always_ff @(posedge clk) begin
    if (rst) qfull <= 1'b0;
    else if (fvalid) qfull <= 1'b1;
    else if (take) qfull <= 1'b0;
    if (fvalid) qjob <= fjob;
  end

  dsd_back u_back (
    .clk, .rst, .job_valid(qfull), .job_take(take), .job(qjob),
    .out_valid, .out_stall, .pcm_out, .decoded, .locked
  );
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import dsd_pkg::*;

  localparam logic [1:0] ModeSpare = 2'd3;  // behaves as pass-through
  localparam logic CmdFrame = 1'b0;
  localparam logic CmdTap = 1'b1;
  localparam int CycleLimit = 40_000_000;
  localparam int DrainCycles = 40;

  typedef struct {
    logic signed [31:0] pcm;
    logic               dec;
    logic               lk;
  } pcm_word_t;

  typedef struct {
    logic               cmd;
    logic [31:0]        smp;
    logic [8:0]         idx;
    logic signed [23:0] val;
    logic               typed;
    pcm_word_t          res;
  } stim_row_t;

  logic clk, rst;
  logic cfg_write;
  logic [0:0] cfg_index;
  logic [1:0] cfg_data;
  logic in_valid, in_stall;
  logic command;
  logic [31:0] sample;
  logic [8:0] tap_index;
  logic signed [23:0] tap_value;
  logic out_valid, out_stall;
  logic signed [31:0] pcm_out;
  logic decoded, locked;

  dop_dsd_lock_and_decimator_top dut (.*);

  // predictor state
  logic [1:0] p_mode, p_natw;
  int unsigned p_vrun, p_irun;
  logic p_lock, p_wide, p_fixed;
  logic [7:0] p_prev;
  logic [7:0] p_hist [HistBytes];
  int unsigned p_hptr;
  int p_taps [TapCount];

  pcm_word_t pending_results[$];
  int mismatches, words_checked, frames_sent, taps_sent, decoded_seen;
  int tx_idle_pct, rx_idle_pct;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word pcm=%h", pcm_out);
      end else begin
        pcm_word_t e;
        e = pending_results.pop_front();
        words_checked++;
        if (decoded) decoded_seen++;
        if (e.pcm !== pcm_out || e.dec !== decoded || e.lk !== locked) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pcm=%h dec=%b lk=%b  got pcm=%h dec=%b lk=%b",
                     e.pcm, e.dec, e.lk, pcm_out, decoded, locked);
        end
      end
    end
  end

  function automatic bit marker_ok(logic [7:0] m);
    return m == MarkA || m == MarkB;
  endfunction

  function automatic void hist_push(logic [7:0] b);
    p_hist[p_hptr] = b;
    p_hptr = (p_hptr + 1) % HistBytes;
  endfunction

  function automatic logic [31:0] fir_value();
    longint acc, y;
    logic [7:0] b;
    acc = 0;
    for (int i = 0; i < HistBytes; i++) begin
      b = p_hist[(p_hptr + HistBytes - 1 - i) % HistBytes];
      for (int m = 0; m < 8; m++) begin
        if (i * 8 + m < TapCount) begin
          if (b[m]) acc += p_taps[i * 8 + m];
          else acc -= p_taps[i * 8 + m];
        end
      end
    end
    y = acc * 512;  // Q1.23 sum times two, to Q1.31
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    return y[31:0];
  endfunction

  // advances the model state; returns 1 when the word yields a result
  function automatic bit predict_word(logic cmd, logic [31:0] s, logic [8:0] idx,
                                      logic signed [23:0] val, output pcm_word_t r);
    logic [7:0] m24, m32, mk;
    logic [15:0] pay;
    bit ok;
    m24 = s[31:24];
    m32 = s[23:16];
    if (cmd == CmdTap) begin
      p_taps[idx] = val;
      return 0;
    end
    if (p_mode == ModeNative) begin
      p_lock = 1'b1;
      hist_push(s[31:24]);
      if (p_natw != NatW8) hist_push(s[23:16]);
      if (p_natw == NatW32) begin
        hist_push(s[15:8]);
        hist_push(s[7:0]);
      end
    end else if (p_mode == ModeDop) begin
      if (!p_fixed) begin
        if (marker_ok(m24)) p_wide = 1'b0;
        else if (marker_ok(m32)) p_wide = 1'b1;
      end
      if (p_wide && (p_fixed || !marker_ok(m24))) begin
        mk = m32;
        pay = s[15:0];
      end else begin
        mk = m24;
        pay = s[23:8];
      end
      ok = marker_ok(mk) && (p_prev == 8'd0 || mk != p_prev);
      if (ok) begin
        if (p_vrun < RunCap) p_vrun++;
        p_irun = 0;
        p_prev = mk;
        if (p_vrun >= 4) p_fixed = 1'b1;
        if (p_vrun >= LockFrames) p_lock = 1'b1;
      end else begin
        if (p_irun < RunCap) p_irun++;
        p_vrun = 0;
        if (p_irun >= ReleaseFrames) begin
          p_prev = 8'd0;
          p_fixed = 1'b0;
          if (p_lock) begin
            p_lock = 1'b0;
            foreach (p_hist[i]) p_hist[i] = Silence;
            p_hptr = 0;
          end
        end
      end
      if (ok || p_lock) begin
        hist_push(pay[15:8]);
        hist_push(pay[7:0]);
      end
    end else begin
      r = '{pcm: s, dec: 1'b0, lk: p_lock};
      return 1;
    end
    if (p_lock) r = '{pcm: fir_value(), dec: 1'b1, lk: 1'b1};
    else r = '{pcm: s, dec: 1'b0, lk: 1'b0};
    return 1;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(logic cmd, logic [31:0] s, logic [8:0] idx,
                           logic signed [23:0] val, bit typed = 0,
                           pcm_word_t typed_res = '{0, 0, 0});
    pcm_word_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      command <= 1'($urandom());
      sample <= $urandom();
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    sample <= s;
    tap_index <= idx;
    tap_value <= val;
    do @(posedge clk); while (in_stall);
    if (predict_word(cmd, s, idx, val, r)) pending_results.push_back(typed ? typed_res : r);
    if (cmd == CmdTap) taps_sent++;
    else frames_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [1:0] data);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == RegMode) p_mode = data;
    else p_natw = data;
  endtask

  function automatic logic signed [23:0] rand_tap();
    case ($urandom_range(9))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2, 3: return 24'($urandom());
      default: return $signed(24'($urandom_range(8191))) - 24'sd4096;
    endcase
  endfunction

  function automatic logic [31:0] dop_frame(logic [7:0] mk, bit wide);
    logic [31:0] s;
    logic [7:0] top;
    s = $urandom();
    if (!wide) return {mk, s[23:0]};
    top = s[31:24];
    if (marker_ok(top)) top = 8'h00;
    return {top, mk, s[15:0]};
  endfunction

  task automatic dop_traffic(int n);
    logic [7:0] mk;
    bit wide;
    int len;
    while (n > 0) begin
      wide = 1'($urandom_range(1));
      mk = $urandom_range(1) ? MarkA : MarkB;
      len = $urandom_range(90, 1);
      for (int i = 0; i < len && n > 0; i++, n--) begin
        if ($urandom_range(40) == 0)
          send_word(CmdTap, $urandom(), 9'($urandom()), rand_tap());
        send_word(CmdFrame, dop_frame(mk, wide), 9'($urandom()), 24'($urandom()));
        mk = (mk == MarkA) ? MarkB : MarkA;
      end
      // broken stretch: repeated marker, noise, or the wrong view
      len = $urandom_range(3) == 0 ? $urandom_range(100, 60) : $urandom_range(12, 1);
      for (int i = 0; i < len && n > 0; i++, n--) begin
        case ($urandom_range(2))
          0: send_word(CmdFrame, dop_frame(mk, wide), 9'($urandom()), 24'($urandom()));
          1: send_word(CmdFrame, $urandom(), 9'($urandom()), 24'($urandom()));
          default: send_word(CmdFrame, dop_frame(mk, !wide), 9'($urandom()),
                             24'($urandom()));
        endcase
      end
    end
  endtask

  task automatic native_traffic(int n);
    repeat (n) begin
      if ($urandom_range(30) == 0) send_word(CmdTap, $urandom(), 9'($urandom()), rand_tap());
      send_word(CmdFrame, $urandom(), 9'($urandom()), 24'($urandom()));
    end
  endtask

  stim_row_t directed[$];

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = RegMode;
    cfg_data = ModePass;
    in_valid = 1'b0;
    command = CmdFrame;
    sample = '0;
    tap_index = '0;
    tap_value = '0;
    tx_idle_pct = 24;
    rx_idle_pct = 75;
    cycles = 0;
    mismatches = 0;
    words_checked = 0;
    frames_sent = 0;
    taps_sent = 0;
    decoded_seen = 0;
    p_mode = ModePass;
    p_natw = NatW16;
    p_vrun = 0;
    p_irun = 0;
    p_lock = 1'b0;
    p_wide = 1'b0;
    p_fixed = 1'b0;
    p_prev = 8'd0;
    p_hptr = 0;
    foreach (p_hist[i]) p_hist[i] = Silence;
    foreach (p_taps[i]) p_taps[i] = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // pass-through after reset, then tap extremes
    directed = '{
      '{CmdFrame, 32'h0000_0000, 9'd0, 24'sd0, 1, '{32'h0000_0000, 1'b0, 1'b0}},
      '{CmdFrame, 32'hFFFF_FFFF, 9'h1FF, -24'sd1, 1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{CmdFrame, 32'h05AA_5500, 9'd0, 24'sd0, 1, '{32'h05AA_5500, 1'b0, 1'b0}},
      '{CmdFrame, 32'h12FA_3456, 9'd0, 24'sd0, 1, '{32'h12FA_3456, 1'b0, 1'b0}},
      '{CmdFrame, 32'h8000_0000, 9'd0, 24'sd0, 1, '{32'h8000_0000, 1'b0, 1'b0}},
      '{CmdTap, 32'hFFFF_FFFF, 9'd0, 24'sh800000, 0, '{0, 0, 0}},
      '{CmdTap, 32'h0, 9'h1FF, 24'sh7FFFFF, 0, '{0, 0, 0}}
    };
    foreach (directed[i])
      send_word(directed[i].cmd, directed[i].smp, directed[i].idx, directed[i].val,
                directed[i].typed, directed[i].res);

    // every tap must hold a value before any decode
    for (int t = 1; t < TapCount - 1; t++)
      send_word(CmdTap, $urandom(), t[8:0], rand_tap());

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 75 : 0;
      rx_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 24 : 0;
      write_reg(RegMode, ModeDop);
      dop_traffic(220);
      write_reg(RegNatWidth, ph == 0 ? NatW8 : ph == 1 ? NatW32 : ModeSpare);
      write_reg(RegMode, ModeNative);
      native_traffic(50);
      write_reg(RegNatWidth, NatW16);
      native_traffic(20);
      write_reg(RegMode, ph == 2 ? ModeSpare : ModePass);
      native_traffic(15);
      // back to DoP with the lock carried over from native mode
      write_reg(RegMode, ModeDop);
      dop_traffic(150);
    end

    drain();
    $display("ran %0d frames and %0d tap writes; %0d results checked, %0d decoded",
             frames_sent, taps_sent, words_checked, decoded_seen);
    $display("modes: pass, spare, DoP in both views, native 8/16/32 bits, lock and release");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d words outstanding", mismatches, pending_results.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
